// File: rtl/alu8f_pkg.sv
`timescale 1ns / 1ps

package alu8f_pkg;

  localparam int unsigned InstrW = 14;
  localparam int unsigned DataW  = 8;
  localparam int unsigned RegW   = 3;

  // instruction field positions
  localparam int unsigned OpHi   = 13;
  localparam int unsigned OpLo   = 11;
  localparam int unsigned DestHi = 10;
  localparam int unsigned DestLo = 8;
  localparam int unsigned ImmSel = 7;
  localparam int unsigned WbBit  = 3;
  localparam int unsigned UnHi   = 2;
  localparam int unsigned UnLo   = 1;

  // binary op codes in bits 13..11, all ones selects a unary op
  typedef enum logic [2:0] {
    OP_ADC   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SBC   = 3'd2,
    OP_SUB   = 3'd3,
    OP_AND   = 3'd4,
    OP_OR    = 3'd5,
    OP_XOR   = 3'd6,
    OP_UNARY = 3'd7
  } op_t;

  // unary op codes in bits 2..1
  typedef enum logic [1:0] {
    UN_NOT = 2'd0,
    UN_ROR = 2'd1,
    UN_SHR = 2'd2,
    UN_RCR = 2'd3
  } unary_t;

  // result of one pass through the execute logic
  typedef struct packed {
    logic [DataW-1:0] result;
    logic             carry;
    logic             zero;
    logic             sign;
  } exec_res_t;

endpackage

// File: rtl/alu8f_exec.sv
`timescale 1ns / 1ps

module alu8f_exec (
  input  logic [alu8f_pkg::InstrW-1:0] instr_word,
  input  logic [alu8f_pkg::DataW-1:0]  first_operand,
  input  logic [alu8f_pkg::DataW-1:0]  second_register_value,
  input  logic                         carry_in,
  output alu8f_pkg::exec_res_t         res
);

  logic [alu8f_pkg::DataW-1:0] a;
  logic [alu8f_pkg::DataW-1:0] b;
  logic [alu8f_pkg::DataW:0]   sum9;
  logic [alu8f_pkg::DataW:0]   diff9;
  logic                        sub_c;
  logic [alu8f_pkg::DataW-1:0] val;
  logic                        cy;
  alu8f_pkg::op_t              op;
  alu8f_pkg::unary_t           un;

  assign a  = first_operand;
  assign op = alu8f_pkg::op_t'(instr_word[alu8f_pkg::OpHi:alu8f_pkg::OpLo]);
  assign un = alu8f_pkg::unary_t'(instr_word[alu8f_pkg::UnHi:alu8f_pkg::UnLo]);

  // second operand: zero-extended 3-bit immediate or register value
  assign b = instr_word[alu8f_pkg::ImmSel]
           ? {{(alu8f_pkg::DataW-3){1'b0}}, instr_word[2:0]}
           : second_register_value;

  // carry only feeds in for the with-carry forms
  assign sub_c = (op == alu8f_pkg::OP_SBC) ? carry_in : 1'b0;

  // shared adder and subtractor, bit 8 is carry or borrow
  assign sum9  = {1'b0, a} + {1'b0, b}
               + {{alu8f_pkg::DataW{1'b0}}, (op == alu8f_pkg::OP_ADC) ? carry_in : 1'b0};
  assign diff9 = {1'b0, a} - {1'b0, b} - {{alu8f_pkg::DataW{1'b0}}, sub_c};

  // operation select
  always_comb begin
    val = '0;
    cy  = 1'b0;
    unique case (op)
      alu8f_pkg::OP_ADC,
      alu8f_pkg::OP_ADD: begin
        val = sum9[alu8f_pkg::DataW-1:0];
        cy  = sum9[alu8f_pkg::DataW];
      end
      alu8f_pkg::OP_SBC,
      alu8f_pkg::OP_SUB: begin
        val = diff9[alu8f_pkg::DataW-1:0];
        cy  = diff9[alu8f_pkg::DataW];
      end
      alu8f_pkg::OP_AND: val = a & b;
      alu8f_pkg::OP_OR:  val = a | b;
      alu8f_pkg::OP_XOR: val = a ^ b;
      alu8f_pkg::OP_UNARY: begin
        unique case (un)
          alu8f_pkg::UN_NOT: val = ~a;
          alu8f_pkg::UN_ROR: val = {a[0], a[alu8f_pkg::DataW-1:1]};
          alu8f_pkg::UN_SHR: begin
            val = {1'b0, a[alu8f_pkg::DataW-1:1]};
            cy  = a[0];
          end
          alu8f_pkg::UN_RCR: begin
            val = {carry_in, a[alu8f_pkg::DataW-1:1]};
            cy  = a[0];
          end
          default: val = '0;
        endcase
      end
      default: val = '0;
    endcase
  end

  // zero and sign flags from the result, carry from the operation
  assign res.result = val;
  assign res.carry  = cy;
  assign res.zero   = (val == '0);
  assign res.sign   = val[alu8f_pkg::DataW-1];

endmodule

// File: rtl/eight_bit_alu_with_flags.sv
`timescale 1ns / 1ps

// Execute stage of a small 8-bit ALU with carry, zero and sign flags.
// Input channel: in_valid / in_stall carry one instruction item: the low 14
// instruction bits plus the two source register values. An item is taken at
// a clock edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall carry the result byte, destination
// code, write-back bit and the flags after the operation.
// An accepted item is captured in the input register, and its result moves
// into the result register, which drives the outputs, once that is free.
// Throughput is one item per cycle while the receiver does not stall; the
// carry flag loop from the result register into the adder sets that figure.
// When the receiver stalls, the result register holds and the input register
// fills; in_stall then rises until the result is taken. Nothing is dropped.
// Reset (rst_n low, synchronous) empties both registers and clears the
// carry, zero and sign flags.
module eight_bit_alu_with_flags (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [alu8f_pkg::InstrW-1:0] in_instr_word,
  input  logic [alu8f_pkg::DataW-1:0]  in_first_operand,
  input  logic [alu8f_pkg::DataW-1:0]  in_second_register_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [alu8f_pkg::DataW-1:0]  out_result,
  output logic [alu8f_pkg::RegW-1:0]   out_dest_code,
  output logic                         out_write_back,
  output logic                         out_carry_out,
  output logic                         out_zero_out,
  output logic                         out_sign_out
);

  logic                         s1_vld_r;
  logic [alu8f_pkg::InstrW-1:0] s1_instr_r;
  logic [alu8f_pkg::DataW-1:0]  s1_a_r;
  logic [alu8f_pkg::DataW-1:0]  s1_b_r;
  logic                         out_vld_r;
  logic                         out_vld_nxt;
  logic [alu8f_pkg::DataW-1:0]  out_result_r;
  logic [alu8f_pkg::RegW-1:0]   out_dest_r;
  logic                         out_wb_r;
  logic                         carry_flag_r;
  logic                         zero_flag_r;
  logic                         sign_flag_r;
  logic                         out_free;
  logic                         advance;
  logic                         accept;
  alu8f_pkg::exec_res_t         ex;

  // handshake
  assign out_free    = !out_vld_r || !out_stall;
  assign advance     = s1_vld_r && out_free;
  assign in_stall    = s1_vld_r && !out_free;
  assign accept      = in_valid && !in_stall;
  assign out_vld_nxt = advance || (out_vld_r && out_stall);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (accept) begin
      s1_vld_r <= 1'b1;
    end else if (advance) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr_r <= in_instr_word;
      s1_a_r     <= in_first_operand;
      s1_b_r     <= in_second_register_value;
    end
  end

  // execute logic
  alu8f_exec u_exec (
    .instr_word            (s1_instr_r),
    .first_operand         (s1_a_r),
    .second_register_value (s1_b_r),
    .carry_in              (carry_flag_r),
    .res                   (ex)
  );

  // flags, updated as each item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r    <= 1'b0;
      carry_flag_r <= 1'b0;
      zero_flag_r  <= 1'b0;
      sign_flag_r  <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        carry_flag_r <= ex.carry;
        zero_flag_r  <= ex.zero;
        sign_flag_r  <= ex.sign;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_result_r <= ex.result;
      out_dest_r   <= s1_instr_r[alu8f_pkg::DestHi:alu8f_pkg::DestLo];
      out_wb_r     <= s1_instr_r[alu8f_pkg::WbBit];
    end
  end

  assign out_valid      = out_vld_r;
  assign out_result     = out_result_r;
  assign out_dest_code  = out_dest_r;
  assign out_write_back = out_wb_r;
  assign out_carry_out  = carry_flag_r;
  assign out_zero_out   = zero_flag_r;
  assign out_sign_out   = sign_flag_r;

`ifndef SYNTH
  // a full input register behind a stalled result must push back
  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_vld_r && out_stall) |-> in_stall)
    else $error("input taken while pipeline blocked");

  // carry only changes when an item moves into the result register
  a_carry_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(carry_flag_r))
    else $error("carry flag changed without an item");

  // zero flag matches the shown result
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (zero_flag_r == (out_result_r == '0)))
    else $error("zero flag disagrees with result");

  // sign flag matches the shown result
  a_sign_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (sign_flag_r == out_result_r[alu8f_pkg::DataW-1]))
    else $error("sign flag disagrees with result");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import alu8f_pkg::*;

  localparam int unsigned RandomItems = 800;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned DrainCycles = 4;

  // one result item as seen on the result channel
  typedef struct {
    logic [DataW-1:0] result;
    logic [RegW-1:0]  dest;
    logic             wb;
    logic             carry;
    logic             zero;
    logic             sign;
  } alu_outcome_t;

  // flag-tracking model of the execute stage plus in-order result checker
  class flag_alu_scoreboard;
    logic         carry_q;
    logic         zero_q;
    logic         sign_q;
    alu_outcome_t pending_outcomes[$];
    int unsigned  error_count;

    function new();
      carry_q     = 1'b0;
      zero_q      = 1'b0;
      sign_q      = 1'b0;
      error_count = 0;
    endfunction

    // compute the result and next flags for one instruction
    function alu_outcome_t exec_instr(logic [InstrW-1:0] instr, logic [DataW-1:0] a,
                                      logic [DataW-1:0] r2);
      alu_outcome_t     o;
      op_t              op;
      unary_t           un;
      logic [DataW-1:0] b;
      logic [DataW:0]   wide;
      logic [DataW-1:0] res;
      op   = op_t'(instr[OpHi:OpLo]);
      un   = unary_t'(instr[UnHi:UnLo]);
      b    = instr[ImmSel] ? {5'b0, instr[2:0]} : r2;
      res  = '0;
      wide = '0;
      case (op)
        OP_ADC: begin
          wide    = {1'b0, a} + {1'b0, b} + {8'b0, carry_q};
          res     = wide[7:0];
          carry_q = wide[8];
        end
        OP_ADD: begin
          wide    = {1'b0, a} + {1'b0, b};
          res     = wide[7:0];
          carry_q = wide[8];
        end
        // bit 8 of the 9-bit difference is the borrow
        OP_SBC: begin
          wide    = {1'b0, a} - {1'b0, b} - {8'b0, carry_q};
          res     = wide[7:0];
          carry_q = wide[8];
        end
        OP_SUB: begin
          wide    = {1'b0, a} - {1'b0, b};
          res     = wide[7:0];
          carry_q = wide[8];
        end
        OP_AND: begin
          res     = a & b;
          carry_q = 1'b0;
        end
        OP_OR: begin
          res     = a | b;
          carry_q = 1'b0;
        end
        OP_XOR: begin
          res     = a ^ b;
          carry_q = 1'b0;
        end
        default: begin
          // unary group, selected by bits 2..1
          case (un)
            UN_NOT: begin
              res     = ~a;
              carry_q = 1'b0;
            end
            UN_ROR: begin
              res     = {a[0], a[7:1]};
              carry_q = 1'b0;
            end
            UN_SHR: begin
              res     = {1'b0, a[7:1]};
              carry_q = a[0];
            end
            default: begin
              res     = {carry_q, a[7:1]};
              carry_q = a[0];
            end
          endcase
        end
      endcase
      zero_q   = (res == '0);
      sign_q   = res[7];
      o.result = res;
      o.dest   = instr[DestHi:DestLo];
      o.wb     = instr[WbBit];
      o.carry  = carry_q;
      o.zero   = zero_q;
      o.sign   = sign_q;
      return o;
    endfunction

    // accepted input item: queue up its expected result
    function void note_item(logic [InstrW-1:0] instr, logic [DataW-1:0] a,
                            logic [DataW-1:0] r2);
      pending_outcomes.push_back(exec_instr(instr, a, r2));
    endfunction

    function void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        error_count++;
      end
    endfunction

    // accepted result item: compare against the oldest expectation
    function void check_result(alu_outcome_t act);
      alu_outcome_t exp_o;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result item, actual result %0h", $time, act.result);
        error_count++;
        return;
      end
      exp_o = pending_outcomes.pop_front();
      cmp_field("result", exp_o.result, act.result);
      cmp_field("dest_code", exp_o.dest, act.dest);
      cmp_field("write_back", exp_o.wb, act.wb);
      cmp_field("carry", exp_o.carry, act.carry);
      cmp_field("zero", exp_o.zero, act.zero);
      cmp_field("sign", exp_o.sign, act.sign);
    endfunction

    function int unsigned pending();
      return pending_outcomes.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [InstrW-1:0]  in_instr_word = '0;
  logic [DataW-1:0]   in_first_operand = '0;
  logic [DataW-1:0]   in_second_register_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DataW-1:0]   out_result;
  logic [RegW-1:0]    out_dest_code;
  logic               out_write_back;
  logic               out_carry_out;
  logic               out_zero_out;
  logic               out_sign_out;

  flag_alu_scoreboard sb = new();
  int unsigned        idle_cycles = 0;
  int unsigned        stall_mode = 0;
  int unsigned        stall_tick = 0;

  eight_bit_alu_with_flags i_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_instr_word            (in_instr_word),
    .in_first_operand         (in_first_operand),
    .in_second_register_value (in_second_register_value),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_result               (out_result),
    .out_dest_code            (out_dest_code),
    .out_write_back           (out_write_back),
    .out_carry_out            (out_carry_out),
    .out_zero_out             (out_zero_out),
    .out_sign_out             (out_sign_out)
  );

  always #10 clk = ~clk;

  // receiver stall pattern, switching mode every so often
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= stall_tick[2];
    endcase
  end

  // watch both channels, feed the scoreboard, count quiet cycles
  always @(posedge clk) begin
    alu_outcome_t seen;
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_item(in_instr_word, in_first_operand, in_second_register_value);
      if (out_valid && !out_stall) begin
        seen.result = out_result;
        seen.dest   = out_dest_code;
        seen.wb     = out_write_back;
        seen.carry  = out_carry_out;
        seen.zero   = out_zero_out;
        seen.sign   = out_sign_out;
        sb.check_result(seen);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [InstrW-1:0] make_instr(op_t op, logic [2:0] dest, logic imm,
                                                   logic [2:0] src, logic wb, logic [2:0] low);
    return {op, dest, imm, src, wb, low};
  endfunction

  // operand with a bias toward the corner values
  function automatic logic [DataW-1:0] pick_byte();
    logic [DataW-1:0] corners[6];
    corners = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 5)];
    return $urandom_range(0, 255);
  endfunction

  // present one item and hold it until taken
  task automatic send_item(logic [InstrW-1:0] instr, logic [DataW-1:0] a,
                           logic [DataW-1:0] r2);
    in_valid                 <= 1'b1;
    in_instr_word            <= instr;
    in_first_operand         <= a;
    in_second_register_value <= r2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic sender_gap(int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off the sender until every expected result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    // adder carry chain, carry into ADC
    send_item(make_instr(OP_ADD, 3'd7, 1'b0, 3'd1, 1'b1, 3'd2), 8'hFF, 8'h01);
    send_item(make_instr(OP_ADC, 3'd0, 1'b0, 3'd2, 1'b1, 3'd3), 8'h7F, 8'h00);
    send_item(make_instr(OP_ADC, 3'd1, 1'b0, 3'd3, 1'b1, 3'd4), 8'hFF, 8'hFF);
    // immediate operand overrides the register value
    send_item(make_instr(OP_ADC, 3'd2, 1'b1, 3'd4, 1'b1, 3'd7), 8'hFF, 8'hAA);
    // borrows
    send_item(make_instr(OP_SUB, 3'd3, 1'b0, 3'd5, 1'b1, 3'd6), 8'h00, 8'h01);
    send_item(make_instr(OP_SBC, 3'd4, 1'b0, 3'd6, 1'b1, 3'd0), 8'h05, 8'h05);
    send_item(make_instr(OP_SBC, 3'd5, 1'b0, 3'd7, 1'b1, 3'd1), 8'h00, 8'h00);
    send_item(make_instr(OP_SUB, 3'd6, 1'b0, 3'd0, 1'b1, 3'd2), 8'h80, 8'h80);
    send_item(make_instr(OP_SBC, 3'd7, 1'b1, 3'd1, 1'b1, 3'd0), 8'hFF, 8'h55);
    send_item(make_instr(OP_SUB, 3'd0, 1'b1, 3'd2, 1'b1, 3'd7), 8'h03, 8'hFF);
    // logic ops, write-back clear still moves the flags
    send_item(make_instr(OP_AND, 3'd1, 1'b0, 3'd3, 1'b0, 3'd4), 8'hF0, 8'h0F);
    send_item(make_instr(OP_OR, 3'd2, 1'b0, 3'd4, 1'b1, 3'd5), 8'h00, 8'h00);
    send_item(make_instr(OP_OR, 3'd3, 1'b0, 3'd5, 1'b0, 3'd6), 8'h80, 8'h01);
    send_item(make_instr(OP_XOR, 3'd4, 1'b0, 3'd6, 1'b1, 3'd7), 8'hFF, 8'hFF);
    send_item(make_instr(OP_XOR, 3'd5, 1'b1, 3'd7, 1'b1, 3'd5), 8'hA5, 8'h00);
    send_item(make_instr(OP_AND, 3'd6, 1'b1, 3'd0, 1'b1, 3'd7), 8'hFF, 8'h00);
    // unary group, with the ignored bits set in some items
    send_item(make_instr(OP_UNARY, 3'd7, 1'b1, 3'd1, 1'b1, {UN_NOT, 1'b1}), 8'hFF, 8'h3C);
    send_item(make_instr(OP_UNARY, 3'd0, 1'b0, 3'd2, 1'b1, {UN_NOT, 1'b0}), 8'h00, 8'hC3);
    send_item(make_instr(OP_UNARY, 3'd1, 1'b1, 3'd3, 1'b1, {UN_ROR, 1'b1}), 8'h01, 8'hFF);
    send_item(make_instr(OP_UNARY, 3'd2, 1'b0, 3'd4, 1'b1, {UN_SHR, 1'b0}), 8'h01, 8'h00);
    send_item(make_instr(OP_UNARY, 3'd3, 1'b1, 3'd5, 1'b1, {UN_RCR, 1'b1}), 8'h00, 8'h11);
    send_item(make_instr(OP_UNARY, 3'd4, 1'b0, 3'd6, 1'b1, {UN_RCR, 1'b0}), 8'hFF, 8'h22);
    send_item(make_instr(OP_UNARY, 3'd5, 1'b1, 3'd7, 1'b0, {UN_RCR, 1'b1}), 8'h02, 8'h33);
    send_item(make_instr(OP_UNARY, 3'd6, 1'b1, 3'd0, 1'b1, {UN_ROR, 1'b1}), 8'hFE, 8'h44);
    send_item(make_instr(OP_ADD, 3'd0, 1'b0, 3'd0, 1'b0, 3'd0), 8'h00, 8'h00);
  endtask

  // random instructions in bursts with random gaps
  task automatic run_random();
    int unsigned sent;
    int unsigned burst;
    bit          mid_drained;
    sent        = 0;
    mid_drained = 1'b0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_item($urandom_range(0, (1 << InstrW) - 1), pick_byte(), pick_byte());
        sent++;
      end
      if (!mid_drained && sent >= RandomItems / 2) begin
        wait_drained();
        mid_drained = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 12));
    end
  endtask

  task automatic run_stimulus();
    run_directed();
    wait_drained();
    run_random();
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    fork
      run_stimulus();
      wait (idle_cycles >= IdleLimit);
    join_any
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, IdleLimit, sb.pending());
      sb.error_count++;
    end
    if (sb.error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
